// ----- hw/rtl/pdr_pkg.sv -----
// Shared constants and trig table construction for the dead-reckoning pose tracker.
`default_nettype none

package pdr_pkg;

   localparam int HEAD_W  = 9;
   localparam int DELTA_W = 10;
   localparam int DIST_W  = 16;
   localparam int QIDX_W  = 7;

   localparam logic [HEAD_W-1:0] FULL_TURN     = 9'd360;
   localparam logic [HEAD_W-1:0] RESET_HEADING = 9'd90;
   localparam logic [HEAD_W-1:0] QUARTER_TURN  = 9'd90;
   localparam logic [HEAD_W-1:0] HALF_TURN     = 9'd180;
   localparam logic [HEAD_W-1:0] THREE_QUARTER = 9'd270;

   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;

   localparam logic [63:0] TAYLOR_DIV [8] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
   };

   // First-quadrant sine of a whole-degree angle in Q2.30, clamped to 0..1.
   function automatic logic [63:0] sine_q30(input logic [QIDX_W-1:0] a);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [64:0] sum;
      x = (64'(a) * PI_Q30 + 64'd90) / 64'd180;
      x2 = (x * x) >> 30;
      term = x;
      sum = $signed({1'b0, x});
      for (int k = 0; k < 8; k++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[k];
         if (k[0] == 1'b0) begin
            sum = sum - $signed({1'b0, term});
         end else begin
            sum = sum + $signed({1'b0, term});
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      if (sum > $signed({1'b0, ONE_Q30})) begin
         sum = $signed({1'b0, ONE_Q30});
      end
      return sum[63:0];
   endfunction

   // The same value rounded half up to frac_bits fraction bits.
   function automatic logic [63:0] quad_entry(input logic [QIDX_W-1:0] a, input int frac_bits);
      logic [63:0] s;
      s = sine_q30(a);
      return (s + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pdr_trig.sv -----
// Whole-degree cosine and sine lookup built on a first-quadrant table.
`default_nettype none

module pdr_trig #(
   parameter int TRIG_FRAC_BITS = 14
) (
   input  wire logic [pdr_pkg::HEAD_W-1:0]        heading,
   output logic signed [TRIG_FRAC_BITS+1:0]       cos_val,
   output logic signed [TRIG_FRAC_BITS+1:0]       sin_val
);
   import pdr_pkg::*;

   localparam int QW = TRIG_FRAC_BITS + 1;
   localparam int VW = TRIG_FRAC_BITS + 2;

   typedef struct packed {
      logic [QIDX_W-1:0] idx;
      logic              neg;
   } fold_type;

   logic [QW-1:0]     quad_tbl [0:90];
   logic [HEAD_W:0]   cos_sum;
   logic [HEAD_W-1:0] cos_deg;
   fold_type          sin_fold;
   fold_type          cos_fold;

   for (genvar a = 0; a <= 90; a++) begin : g_tbl
      assign quad_tbl[a] = QW'(quad_entry(QIDX_W'(a), TRIG_FRAC_BITS));
   end

   function automatic fold_type fold(input logic [HEAD_W-1:0] d);
      fold_type f;
      priority if (d <= QUARTER_TURN) begin
         f.idx = QIDX_W'(d);
         f.neg = 1'b0;
      end else if (d <= HALF_TURN) begin
         f.idx = QIDX_W'(HALF_TURN - d);
         f.neg = 1'b0;
      end else if (d <= THREE_QUARTER) begin
         f.idx = QIDX_W'(d - HALF_TURN);
         f.neg = 1'b1;
      end else begin
         f.idx = QIDX_W'(FULL_TURN - d);
         f.neg = 1'b1;
      end
      return f;
   endfunction

   function automatic logic signed [VW-1:0] apply(input fold_type f,
                                                  input logic [QW-1:0] q);
      logic signed [VW-1:0] v;
      v = $signed({1'b0, q});
      return f.neg ? -v : v;
   endfunction

   always_comb begin
      cos_sum = {1'b0, heading} + {1'b0, QUARTER_TURN};
      if (cos_sum >= {1'b0, FULL_TURN}) begin
         cos_deg = HEAD_W'(cos_sum - {1'b0, FULL_TURN});
      end else begin
         cos_deg = cos_sum[HEAD_W-1:0];
      end
      sin_fold = fold(heading);
      cos_fold = fold(cos_deg);
      sin_val = apply(sin_fold, quad_tbl[sin_fold.idx]);
      cos_val = apply(cos_fold, quad_tbl[cos_fold.idx]);
   end

endmodule

`default_nettype wire

// ----- hw/rtl/pose_dead_reckoning.sv -----
// Top level of the dead-reckoning pose tracker: heading update and position accumulation.
//
// Channel   Direction  Handshake             Contents
// req       in         req_valid/req_ready   action, angle delta, distance, compass heading
// rsp       out        rsp_valid/rsp_ready   x and y position, heading
// csr       in         csr_wr_en             compass mode bit
//
// A transaction is captured in an input register, then the heading wrap, table lookup,
// two multiplies and saturating accumulate run combinationally into the pose registers,
// which hold the result; one transaction per cycle while the result is not stalled.
// The pose registers double as the result register, so a stalled result holds the
// next transaction in the input register. Reset sets heading 90 and position zero.
`default_nettype none

module pose_dead_reckoning #(
   parameter int TRIG_FRAC_BITS = 14,
   parameter int POS_WIDTH      = 40
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_action,
   input  wire logic signed [pdr_pkg::DELTA_W-1:0]   req_angle_delta,
   input  wire logic signed [pdr_pkg::DIST_W-1:0]    req_distance_mm,
   input  wire logic        [pdr_pkg::HEAD_W-1:0]    req_compass_heading,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [POS_WIDTH-1:0]               rsp_pos_x,
   output logic signed [POS_WIDTH-1:0]               rsp_pos_y,
   output logic        [pdr_pkg::HEAD_W-1:0]         rsp_heading_deg,
   input  wire logic                                 csr_wr_en,
   input  wire logic                                 csr_wr_data
);
   import pdr_pkg::*;

   localparam int VW     = TRIG_FRAC_BITS + 2;
   localparam int PROD_W = DIST_W + VW;
   localparam int SUM_W  = ((POS_WIDTH > PROD_W) ? POS_WIDTH : PROD_W) + 1;
   localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'({1'b0, {(POS_WIDTH-1){1'b1}}});
   localparam logic signed [SUM_W-1:0] POS_MIN = ~POS_MAX;

   logic                       compass_mode_ff;
   logic                       in_valid_ff;
   logic                       in_action_ff;
   logic signed [DELTA_W-1:0]  in_delta_ff;
   logic signed [DIST_W-1:0]   in_dist_ff;
   logic [HEAD_W-1:0]          in_compass_ff;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   logic signed [POS_WIDTH-1:0] x_ff;
   logic signed [POS_WIDTH-1:0] x_in;
   logic signed [POS_WIDTH-1:0] y_ff;
   logic signed [POS_WIDTH-1:0] y_in;
   logic [HEAD_W-1:0]          heading_ff;
   logic [HEAD_W-1:0]          heading_in;

   logic                       fire;
   logic signed [11:0]         h_sum;
   logic [HEAD_W-1:0]          h_delta;
   logic [HEAD_W-1:0]          h_compass;
   logic [HEAD_W-1:0]          h_new;
   logic signed [VW-1:0]       cos_val;
   logic signed [VW-1:0]       sin_val;
   logic signed [PROD_W-1:0]   prod_x;
   logic signed [PROD_W-1:0]   prod_y;
   logic signed [SUM_W-1:0]    sum_x;
   logic signed [SUM_W-1:0]    sum_y;

   function automatic logic signed [POS_WIDTH-1:0] saturate(input logic signed [SUM_W-1:0] v);
      priority if (v > POS_MAX) begin
         return POS_MAX[POS_WIDTH-1:0];
      end else if (v < POS_MIN) begin
         return POS_MIN[POS_WIDTH-1:0];
      end else begin
         return v[POS_WIDTH-1:0];
      end
   endfunction

   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      h_sum = $signed({3'b000, heading_ff}) + $signed({{2{in_delta_ff[DELTA_W-1]}}, in_delta_ff});
      priority if (h_sum < -12'sd360) begin
         h_delta = HEAD_W'(h_sum + 12'sd720);
      end else if (h_sum < 12'sd0) begin
         h_delta = HEAD_W'(h_sum + 12'sd360);
      end else if (h_sum < 12'sd360) begin
         h_delta = h_sum[HEAD_W-1:0];
      end else if (h_sum < 12'sd720) begin
         h_delta = HEAD_W'(h_sum - 12'sd360);
      end else begin
         h_delta = HEAD_W'(h_sum - 12'sd720);
      end
      if (in_compass_ff >= FULL_TURN) begin
         h_compass = in_compass_ff - FULL_TURN;
      end else begin
         h_compass = in_compass_ff;
      end
      h_new = compass_mode_ff ? h_compass : h_delta;
   end

   pdr_trig #(
      .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
   ) u_trig (
      .heading(h_new),
      .cos_val(cos_val),
      .sin_val(sin_val)
   );

   always_comb begin
      prod_x = in_dist_ff * cos_val;
      prod_y = in_dist_ff * sin_val;
      sum_x  = SUM_W'(x_ff) + SUM_W'(prod_x);
      sum_y  = SUM_W'(y_ff) + SUM_W'(prod_y);

      out_valid_in = out_valid_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      heading_in   = heading_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (fire) begin
         out_valid_in = 1'b1;
         if (in_action_ff) begin
            x_in       = '0;
            y_in       = '0;
            heading_in = RESET_HEADING;
         end else begin
            x_in       = saturate(sum_x);
            y_in       = saturate(sum_y);
            heading_in = h_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compass_mode_ff <= 1'b0;
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         x_ff            <= '0;
         y_ff            <= '0;
         heading_ff      <= RESET_HEADING;
      end else begin
         if (csr_wr_en) begin
            compass_mode_ff <= csr_wr_data;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         out_valid_ff <= out_valid_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         heading_ff   <= heading_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_action_ff  <= req_action;
         in_delta_ff   <= req_angle_delta;
         in_dist_ff    <= req_distance_mm;
         in_compass_ff <= req_compass_heading;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pos_x       = x_ff;
   assign rsp_pos_y       = y_ff;
   assign rsp_heading_deg = heading_ff;

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      heading_ff < FULL_TURN)
      else $error("heading left the 0..359 range");

   a_reset_pose: assert property (@(posedge clock) disable iff (reset)
      fire && in_action_ff |=> x_ff == '0 && y_ff == '0 && heading_ff == RESET_HEADING)
      else $error("reset action did not restore the origin pose");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !fire)
      else $error("pose updated while a result was stalled");

   a_pose_held: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(x_ff) && $stable(y_ff) && $stable(heading_ff))
      else $error("pose changed without a transaction");

endmodule

`default_nettype wire

// ----- tb/pose_dead_reckoning_tb.sv -----
// Testbench for the dead-reckoning pose tracker, with a scoreboard that predicts each pose.
`timescale 1ns / 1ps

module pose_dead_reckoning_tb;

   localparam int FRAC_BITS = 14;
   localparam int POS_W = 40;
   localparam int STALL_LIMIT = 2000;
   localparam int TURN = 360;
   localparam int HOME_HEADING = 90;
   localparam longint unsigned PI_FIX30 = 64'd3373259426;
   localparam longint UNIT_FIX30 = 64'sd1073741824;
   localparam longint POS_MAX = (64'sd1 <<< (POS_W - 1)) - 1;
   localparam longint POS_MIN = -POS_MAX - 1;

   localparam bit ACT_UPDATE = 1'b0;
   localparam bit ACT_HOME = 1'b1;
   localparam bit MODE_DELTA = 1'b0;
   localparam bit MODE_COMPASS = 1'b1;

   typedef struct {
      logic signed [POS_W-1:0]        x;
      logic signed [POS_W-1:0]        y;
      logic [pdr_pkg::HEAD_W-1:0]     heading;
   } pose_type;

   // Sine of a whole degree in 0..90, series in Q30, rounded to FRAC_BITS.
   function automatic longint quarter_sine(int unsigned deg);
      longint unsigned rad;
      longint unsigned rad_sq;
      longint unsigned term;
      longint acc;
      rad = (longint'(deg) * PI_FIX30 + 64'd90) / 64'd180;
      rad_sq = (rad * rad) >> 30;
      term = rad;
      acc = longint'(rad);
      for (int k = 1; k <= 8; k++) begin
         term = ((term * rad_sq) >> 30) / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > UNIT_FIX30) begin
         acc = UNIT_FIX30;
      end
      return (acc + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
   endfunction

   function automatic longint sine_of(int deg);
      if (deg <= 90) begin
         return quarter_sine(deg);
      end
      if (deg <= 180) begin
         return quarter_sine(180 - deg);
      end
      if (deg <= 270) begin
         return -quarter_sine(deg - 180);
      end
      return -quarter_sine(360 - deg);
   endfunction

   function automatic longint clamp_pos(longint v);
      if (v > POS_MAX) begin
         return POS_MAX;
      end
      if (v < POS_MIN) begin
         return POS_MIN;
      end
      return v;
   endfunction

   class pose_scoreboard;
      bit compass_mode = MODE_DELTA;
      int heading = HOME_HEADING;
      longint x_pos = 0;
      longint y_pos = 0;
      int errors = 0;
      pose_type expected_poses[$];

      function int pending();
         return expected_poses.size();
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= 40) begin
            $display("ERROR at %0t: %s", $realtime, msg);
         end
      endtask

      function void note_update(bit action, logic signed [pdr_pkg::DELTA_W-1:0] delta,
                                logic signed [pdr_pkg::DIST_W-1:0] distance,
                                logic [pdr_pkg::HEAD_W-1:0] compass);
         pose_type p;
         int h;
         if (action == ACT_HOME) begin
            x_pos = 0;
            y_pos = 0;
            heading = HOME_HEADING;
         end else begin
            if (compass_mode == MODE_COMPASS) begin
               h = int'(compass);
            end else begin
               h = heading + int'(delta);
            end
            h = h % TURN;
            if (h < 0) begin
               h += TURN;
            end
            heading = h;
            if (distance != 0) begin
               x_pos = clamp_pos(x_pos + longint'(distance) * sine_of((heading + 90) % TURN));
               y_pos = clamp_pos(y_pos + longint'(distance) * sine_of(heading));
            end
         end
         p.x = x_pos[POS_W-1:0];
         p.y = y_pos[POS_W-1:0];
         p.heading = heading[pdr_pkg::HEAD_W-1:0];
         expected_poses.push_back(p);
      endfunction

      task check_pose(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                      logic [pdr_pkg::HEAD_W-1:0] ph);
         pose_type want;
         if (expected_poses.size() == 0) begin
            report_mismatch("result with no transaction outstanding");
         end else begin
            want = expected_poses.pop_front();
            if (px !== want.x) begin
               report_mismatch($sformatf("pos_x got %0d expected %0d", px, want.x));
            end
            if (py !== want.y) begin
               report_mismatch($sformatf("pos_y got %0d expected %0d", py, want.y));
            end
            if (ph !== want.heading) begin
               report_mismatch($sformatf("heading got %0d expected %0d", ph, want.heading));
            end
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_action = 1'b0;
   logic signed [pdr_pkg::DELTA_W-1:0] req_angle_delta = '0;
   logic signed [pdr_pkg::DIST_W-1:0] req_distance_mm = '0;
   logic [pdr_pkg::HEAD_W-1:0] req_compass_heading = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [POS_W-1:0] rsp_pos_x;
   logic signed [POS_W-1:0] rsp_pos_y;
   logic [pdr_pkg::HEAD_W-1:0] rsp_heading_deg;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   int req_idle_pct = 21;
   int rsp_idle_pct = 84;
   int stall_cycles = 0;
   pose_scoreboard sb = new;

   pose_dead_reckoning #(
      .TRIG_FRAC_BITS (FRAC_BITS),
      .POS_WIDTH      (POS_W)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_angle_delta     (req_angle_delta),
      .req_distance_mm     (req_distance_mm),
      .req_compass_heading (req_compass_heading),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pos_x           (rsp_pos_x),
      .rsp_pos_y           (rsp_pos_y),
      .rsp_heading_deg     (rsp_heading_deg),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_pose(rsp_pos_x, rsp_pos_y, rsp_heading_deg);
         end
         if (req_valid && req_ready) begin
            sb.note_update(req_action, req_angle_delta, req_distance_mm, req_compass_heading);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("pose_dead_reckoning_tb failed");
         $finish;
      end
   end

   task automatic send_update(bit action, int delta, int distance, int compass);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_angle_delta <= pdr_pkg::DELTA_W'(delta);
      req_distance_mm <= pdr_pkg::DIST_W'(distance);
      req_compass_heading <= pdr_pkg::HEAD_W'(compass);
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic drain_poses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(bit mode);
      csr_wr_en <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.compass_mode = mode;
   endtask

   task automatic random_items(int count);
      int r;
      int distance;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            send_update(ACT_HOME, int'($urandom), int'($urandom), int'($urandom));
         end else if (r < 15) begin
            send_update(ACT_UPDATE, int'($urandom), int'($urandom), int'($urandom));
         end else begin
            r = $urandom_range(0, 9);
            if (r < 2) begin
               distance = 0;
            end else if (r < 6) begin
               distance = int'($urandom_range(0, 4000)) - 2000;
            end else begin
               distance = int'($urandom);
            end
            send_update(ACT_UPDATE, int'($urandom_range(0, 60)) - 30, distance,
                        int'($urandom_range(0, TURN - 1)));
         end
      end
   endtask

   // Straight run along one axis from the origin, long enough to reach saturation.
   task automatic long_haul(int count);
      int dir;
      bit backward;
      int delta;
      int compass;
      int distance;
      dir = 90 * int'($urandom_range(0, 3));
      backward = bit'($urandom_range(0, 1));
      send_update(ACT_HOME, 0, 0, 0);
      send_update(ACT_UPDATE, dir - HOME_HEADING, 0, dir);
      for (int i = 0; i < count; i++) begin
         delta = 360 * (int'($urandom_range(0, 2)) - 1);
         compass = dir;
         if (dir + TURN <= 511 && $urandom_range(0, 1) != 0) begin
            compass = dir + TURN;
         end
         if (backward) begin
            distance = -int'($urandom_range(30000, 32768));
         end else begin
            distance = int'($urandom_range(30000, 32767));
         end
         send_update(ACT_UPDATE, delta, distance, compass);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_mode(MODE_DELTA);

      send_update(ACT_UPDATE, 0, 0, 0);
      send_update(ACT_UPDATE, 359, 32767, 0);
      send_update(ACT_UPDATE, -359, -32768, 511);
      send_update(ACT_UPDATE, 511, 1, 0);
      send_update(ACT_UPDATE, -512, -1, 0);
      send_update(ACT_UPDATE, 45, 0, 0);
      send_update(ACT_HOME, -512, -32768, 511);
      send_update(ACT_UPDATE, -90, 1000, 0);
      send_update(ACT_UPDATE, 180, 1000, 0);
      send_update(ACT_UPDATE, 90, 1000, 0);
      send_update(ACT_UPDATE, 90, -1000, 0);
      send_update(ACT_UPDATE, 0, 32767, 0);
      drain_poses();

      write_mode(MODE_COMPASS);
      send_update(ACT_UPDATE, 0, 32767, 0);
      send_update(ACT_UPDATE, 0, -32768, 359);
      send_update(ACT_UPDATE, 0, 500, 360);
      send_update(ACT_UPDATE, 0, 12345, 511);
      send_update(ACT_UPDATE, -512, 0, 180);
      send_update(ACT_HOME, 511, 32767, 511);
      send_update(ACT_UPDATE, 0, 7, 270);
      send_update(ACT_UPDATE, 0, -7, 90);
      drain_poses();

      write_mode(MODE_DELTA);
      random_items(225);
      drain_poses();

      req_idle_pct <= 84;
      rsp_idle_pct <= 21;
      write_mode(MODE_COMPASS);
      random_items(225);
      drain_poses();

      req_idle_pct <= 0;
      rsp_idle_pct <= 0;
      write_mode(bit'($urandom_range(0, 1)));
      random_items(60);
      long_haul(1180);
      random_items(60);
      drain_poses();

      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("pose_dead_reckoning_tb passed");
      end else begin
         $display("pose_dead_reckoning_tb failed");
      end
      $finish;
   end

endmodule
